>>> design/ntw_pkg.sv
// Shared types, widths and constants of the night tint window schedule unit.
package ntw_pkg;

  localparam int FRAC_BITS = 16;
  localparam int Q_W = FRAC_BITS + 1;
  localparam int SEC_W = 17;
  localparam int MIN_W = 11;
  localparam int FADE_W = 10;
  localparam int DSEC_W = 16;
  localparam int MODE_W = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = (Q_W > MIN_W) ? Q_W : MIN_W;

  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int FRONT_STAGES = 3;

  localparam logic [Q_W-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS+1:0] THREE_ONE_Q = {2'b11, {FRAC_BITS{1'b0}}};
  localparam logic [SEC_W-1:0] SEC_PER_DAY = SEC_W'(86400);
  localparam logic [MIN_W-1:0] MIN_PER_DAY = MIN_W'(1440);

  localparam logic [MIN_W-1:0] RST_START_MIN = MIN_W'(1320);
  localparam logic [MIN_W-1:0] RST_END_MIN = MIN_W'(420);
  localparam logic [FADE_W-1:0] RST_FADE_MIN = FADE_W'(30);

  typedef enum logic [MODE_W-1:0] {
    MODE_WINDOW = 2'd0,
    MODE_FULL   = 2'd1,
    MODE_ZERO   = 2'd2
  } ntw_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHIFT_ENABLE = 3'd0,
    REG_SCHEDULE_MODE = 3'd1,
    REG_WINDOW_START = 3'd2,
    REG_WINDOW_END = 3'd3,
    REG_FADE_MINUTES = 3'd4,
    REG_TARGET_RED = 3'd5,
    REG_TARGET_GREEN = 3'd6,
    REG_TARGET_BLUE = 3'd7
  } ntw_reg_t;

  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_FULL = 2'd1,
    CLS_FADE = 2'd2,
    CLS_WIN  = 2'd3
  } ntw_class_t;

  typedef struct packed {
    logic              shift_enable;
    logic [MODE_W-1:0] schedule_mode;
    logic [MIN_W-1:0]  window_start_minute;
    logic [MIN_W-1:0]  window_end_minute;
    logic [FADE_W-1:0] fade_minutes;
    logic [Q_W-1:0]    target_gain_red;
    logic [Q_W-1:0]    target_gain_green;
    logic [Q_W-1:0]    target_gain_blue;
  } ntw_cfg_t;

  typedef struct packed {
    ntw_class_t        cls;
    logic [DSEC_W-1:0] dist_sec;
    logic [DSEC_W-1:0] fade_sec;
  } ntw_item_t;

endpackage

>>> design/ntw_front.sv
// Front end: accepts time beats, reduces the schedule and classifies each beat.
module ntw_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic [ntw_pkg::SEC_W-1:0] time_of_day_sec,
  input  logic                      time_valid,
  input  ntw_pkg::ntw_cfg_t         cfg,
  output logic                      push,
  output ntw_pkg::ntw_item_t        push_item,
  output logic [1:0]                inflight
);
  import ntw_pkg::*;

  logic              a_vld_r;
  ntw_class_t        a_cls_r, a_cls_nxt;
  logic [SEC_W-1:0]  a_now_r, a_now_nxt;
  logic [SEC_W-1:0]  a_start_sec_r, a_start_sec_nxt;
  logic [SEC_W-1:0]  a_dur_sec_r, a_dur_sec_nxt;
  logic [DSEC_W-1:0] a_fade_sec_r, a_fade_sec_nxt;
  logic [MIN_W-1:0]  start_red, end_red, dur_min;

  logic              b_vld_r;
  ntw_class_t        b_cls_r;
  logic [SEC_W-1:0]  b_since_r, b_since_nxt;
  logic [SEC_W-1:0]  b_dur_sec_r;
  logic [DSEC_W-1:0] b_fade_sec_r;

  logic              c_vld_r;
  ntw_item_t         c_item_r, c_item_nxt;
  logic [SEC_W-1:0]  rest_sec, dist_full;
  logic              in_window;

  always_comb begin
    a_now_nxt = (time_of_day_sec >= SEC_PER_DAY) ? time_of_day_sec - SEC_PER_DAY
                                                 : time_of_day_sec;
    start_red = (cfg.window_start_minute >= MIN_PER_DAY)
                ? cfg.window_start_minute - MIN_PER_DAY : cfg.window_start_minute;
    end_red = (cfg.window_end_minute >= MIN_PER_DAY)
              ? cfg.window_end_minute - MIN_PER_DAY : cfg.window_end_minute;
    dur_min = (end_red >= start_red) ? end_red - start_red
                                     : end_red + (MIN_PER_DAY - start_red);
    a_start_sec_nxt = SEC_W'({SEC_W'(start_red), 6'b0} - {SEC_W'(start_red), 2'b0});
    a_dur_sec_nxt = SEC_W'({SEC_W'(dur_min), 6'b0} - {SEC_W'(dur_min), 2'b0});
    a_fade_sec_nxt = DSEC_W'({DSEC_W'(cfg.fade_minutes), 6'b0}
                             - {DSEC_W'(cfg.fade_minutes), 2'b0});
    a_cls_nxt = CLS_ZERO;
    if (cfg.shift_enable) begin
      unique case (cfg.schedule_mode)
        MODE_FULL:   a_cls_nxt = CLS_FULL;
        MODE_WINDOW: a_cls_nxt = time_valid ? CLS_WIN : CLS_ZERO;
        default:     a_cls_nxt = CLS_ZERO;
      endcase
    end
  end

  always_comb begin
    b_since_nxt = (a_now_r >= a_start_sec_r) ? a_now_r - a_start_sec_r
                                             : a_now_r + (SEC_PER_DAY - a_start_sec_r);
  end

  always_comb begin
    in_window = (b_dur_sec_r != '0) && (b_since_r < b_dur_sec_r);
    rest_sec = b_dur_sec_r - b_since_r;
    dist_full = (b_since_r < rest_sec) ? b_since_r : rest_sec;
    c_item_nxt.dist_sec = dist_full[DSEC_W-1:0];
    c_item_nxt.fade_sec = b_fade_sec_r;
    unique case (b_cls_r)
      CLS_WIN: begin
        if (!in_window) begin
          c_item_nxt.cls = CLS_ZERO;
        end else if (b_fade_sec_r == '0) begin
          c_item_nxt.cls = CLS_FULL;
        end else if (dist_full >= SEC_W'(b_fade_sec_r)) begin
          c_item_nxt.cls = CLS_FULL;
        end else begin
          c_item_nxt.cls = CLS_FADE;
        end
      end
      default: c_item_nxt.cls = b_cls_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= accept;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_cls_r <= a_cls_nxt;
    a_now_r <= a_now_nxt;
    a_start_sec_r <= a_start_sec_nxt;
    a_dur_sec_r <= a_dur_sec_nxt;
    a_fade_sec_r <= a_fade_sec_nxt;
    b_cls_r <= a_cls_r;
    b_since_r <= b_since_nxt;
    b_dur_sec_r <= a_dur_sec_r;
    b_fade_sec_r <= a_fade_sec_r;
    c_item_r <= c_item_nxt;
  end

  assign push = c_vld_r;
  assign push_item = c_item_r;
  assign inflight = 2'(a_vld_r) + 2'(b_vld_r) + 2'(c_vld_r);

endmodule

>>> design/ntw_queue.sv
// Short queue between the front end and the back end.
module ntw_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  ntw_pkg::ntw_item_t         push_item,
  output logic                       pop,
  output ntw_pkg::ntw_item_t         pop_item,
  output logic [ntw_pkg::QCNT_W-1:0] count
);
  import ntw_pkg::*;

  ntw_item_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign pop = (count_r != '0);
  assign pop_item = mem_r[rd_ptr_r];
  assign count = count_r;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && count_r == QCNT_W'(QUEUE_DEPTH)) |-> pop)
    else $error("queue written while full");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + QCNT_W'(1)))
    else $error("queue count did not advance on a lone push");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");
`endif

endmodule

>>> design/ntw_back.sv
// Back end: fade divider, smoothstep and gain blending pipeline.
module ntw_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     pop,
  input  ntw_pkg::ntw_item_t       pop_item,
  input  ntw_pkg::ntw_cfg_t        cfg,
  output logic                     out_strobe,
  output logic [ntw_pkg::Q_W-1:0]  out_strength,
  output logic [ntw_pkg::Q_W-1:0]  out_gain_red,
  output logic [ntw_pkg::Q_W-1:0]  out_gain_green,
  output logic [ntw_pkg::Q_W-1:0]  out_gain_blue
);
  import ntw_pkg::*;

  localparam int SQ_W = 2 * FRAC_BITS;
  localparam int ST_W = 2 * FRAC_BITS + 2;
  localparam int GP_W = 2 * Q_W;

  logic              dv_r  [FRAC_BITS+1];
  ntw_class_t        dcls_r [FRAC_BITS+1];
  logic [DSEC_W-1:0] rem_r [FRAC_BITS+1];
  logic [DSEC_W-1:0] div_r [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] quo_r [FRAC_BITS+1];
  logic [DSEC_W:0]   shl [FRAC_BITS];
  logic [DSEC_W:0]   sub [FRAC_BITS];
  logic              ge  [FRAC_BITS];

  logic                 sq_v_r;
  ntw_class_t           sq_cls_r;
  logic [FRAC_BITS-1:0] sq_x_r;
  logic [SQ_W-1:0]      sq_prod_r, sq_prod_nxt;

  logic                 st_v_r;
  ntw_class_t           st_cls_r;
  logic [ST_W-1:0]      st_prod_r, st_prod_nxt;
  logic [FRAC_BITS+1:0] weight;

  logic                 gm_v_r;
  logic [Q_W-1:0]       gm_s_r, gm_s_nxt;
  logic [GP_W-1:0]      gm_prod_r [3];
  logic [GP_W-1:0]      gm_prod_nxt [3];
  logic [Q_W-1:0]       tgt [3];
  logic [Q_W-1:0]       diff [3];

  logic [Q_W-1:0]       strength_r;
  logic [Q_W-1:0]       gain_r [3];
  logic                 strobe_r;

  always_comb begin
    for (int i = 0; i < FRAC_BITS; i++) begin
      shl[i] = {rem_r[i], 1'b0};
      ge[i] = (shl[i] >= {1'b0, div_r[i]});
      sub[i] = shl[i] - {1'b0, div_r[i]};
    end
  end

  always_comb begin
    sq_prod_nxt = SQ_W'(quo_r[FRAC_BITS]) * SQ_W'(quo_r[FRAC_BITS]);
    weight = THREE_ONE_Q - {1'b0, sq_x_r, 1'b0};
    st_prod_nxt = ST_W'(sq_prod_r[SQ_W-1:FRAC_BITS]) * ST_W'(weight);
    unique case (st_cls_r)
      CLS_FADE: gm_s_nxt = st_prod_r[2*FRAC_BITS:FRAC_BITS];
      CLS_FULL: gm_s_nxt = ONE_Q;
      default:  gm_s_nxt = '0;
    endcase
    tgt[0] = cfg.target_gain_red;
    tgt[1] = cfg.target_gain_green;
    tgt[2] = cfg.target_gain_blue;
    for (int c = 0; c < 3; c++) begin
      diff[c] = (tgt[c] > ONE_Q) ? '0 : ONE_Q - tgt[c];
      gm_prod_nxt[c] = GP_W'(diff[c]) * GP_W'(gm_s_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= FRAC_BITS; i++) begin
        dv_r[i] <= 1'b0;
      end
      sq_v_r <= 1'b0;
      st_v_r <= 1'b0;
      gm_v_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      dv_r[0] <= pop;
      for (int i = 0; i < FRAC_BITS; i++) begin
        dv_r[i+1] <= dv_r[i];
      end
      sq_v_r <= dv_r[FRAC_BITS];
      st_v_r <= sq_v_r;
      gm_v_r <= st_v_r;
      strobe_r <= gm_v_r;
    end
  end

  always_ff @(posedge clk) begin
    dcls_r[0] <= pop_item.cls;
    rem_r[0] <= pop_item.dist_sec;
    div_r[0] <= pop_item.fade_sec;
    quo_r[0] <= '0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      dcls_r[i+1] <= dcls_r[i];
      div_r[i+1] <= div_r[i];
      rem_r[i+1] <= ge[i] ? sub[i][DSEC_W-1:0] : shl[i][DSEC_W-1:0];
      quo_r[i+1] <= {quo_r[i][FRAC_BITS-2:0], ge[i]};
    end
    sq_cls_r <= dcls_r[FRAC_BITS];
    sq_x_r <= quo_r[FRAC_BITS];
    sq_prod_r <= sq_prod_nxt;
    st_cls_r <= sq_cls_r;
    st_prod_r <= st_prod_nxt;
    gm_s_r <= gm_s_nxt;
    for (int c = 0; c < 3; c++) begin
      gm_prod_r[c] <= gm_prod_nxt[c];
      gain_r[c] <= ONE_Q - gm_prod_r[c][2*FRAC_BITS:FRAC_BITS];
    end
    strength_r <= gm_s_r;
  end

  assign out_strobe = strobe_r;
  assign out_strength = strength_r;
  assign out_gain_red = gain_r[0];
  assign out_gain_green = gain_r[1];
  assign out_gain_blue = gain_r[2];

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[0] |-> ##(FRAC_BITS + 4) out_strobe)
    else $error("beat lost in the back end pipeline");
  a_strength_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_strength <= ONE_Q))
    else $error("strength above full scale");
  a_zero_neutral: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_strength == '0) |->
      (out_gain_red == ONE_Q && out_gain_green == ONE_Q && out_gain_blue == ONE_Q))
    else $error("gains not neutral at zero strength");
`endif

endmodule

>>> design/night_tint_window_schedule_unit.sv
// Top level of the night tint window schedule unit with its configuration registers.
//
// Each time beat taken on start gives one result beat, strobed on out_strobe for a
// single cycle, with strength and gains in Q1.16. A new beat can be taken every
// cycle while busy is low: the front end classifies each beat in three stages, an
// eight-entry queue hands it to the back end, and the back end runs a restoring
// divider of one quotient bit per stage for the fade ramp, two multiplier stages
// for smoothstep and one for the gain blend. The receiver cannot stall results,
// so the queue drains every cycle and busy rises only if the queue and the front
// end together could hold more beats than the queue has room for. Configuration
// writes take effect on the next cycle and should be made while no beat is in flight.
module night_tint_window_schedule_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [ntw_pkg::SEC_W-1:0]      in_time_of_day_sec,
  input  logic                           in_time_valid,
  output logic                           out_strobe,
  output logic [ntw_pkg::Q_W-1:0]        out_strength,
  output logic [ntw_pkg::Q_W-1:0]        out_gain_red,
  output logic [ntw_pkg::Q_W-1:0]        out_gain_green,
  output logic [ntw_pkg::Q_W-1:0]        out_gain_blue,
  input  logic                           cfg_we,
  input  logic [ntw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ntw_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ntw_pkg::*;

  ntw_cfg_t          cfg_r;
  logic              accept;
  logic              push, pop;
  ntw_item_t         push_item, pop_item;
  logic [1:0]        inflight;
  logic [QCNT_W-1:0] q_count;
  logic [QCNT_W:0]   held;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shift_enable <= 1'b0;
      cfg_r.schedule_mode <= MODE_WINDOW;
      cfg_r.window_start_minute <= RST_START_MIN;
      cfg_r.window_end_minute <= RST_END_MIN;
      cfg_r.fade_minutes <= RST_FADE_MIN;
      cfg_r.target_gain_red <= ONE_Q;
      cfg_r.target_gain_green <= ONE_Q;
      cfg_r.target_gain_blue <= ONE_Q;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHIFT_ENABLE:  cfg_r.shift_enable <= cfg_wdata[0];
        REG_SCHEDULE_MODE: cfg_r.schedule_mode <= cfg_wdata[MODE_W-1:0];
        REG_WINDOW_START:  cfg_r.window_start_minute <= cfg_wdata[MIN_W-1:0];
        REG_WINDOW_END:    cfg_r.window_end_minute <= cfg_wdata[MIN_W-1:0];
        REG_FADE_MINUTES:  cfg_r.fade_minutes <= cfg_wdata[FADE_W-1:0];
        REG_TARGET_RED:    cfg_r.target_gain_red <= cfg_wdata[Q_W-1:0];
        REG_TARGET_GREEN:  cfg_r.target_gain_green <= cfg_wdata[Q_W-1:0];
        REG_TARGET_BLUE:   cfg_r.target_gain_blue <= cfg_wdata[Q_W-1:0];
        default: ;
      endcase
    end
  end

  assign held = (QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(inflight);
  assign busy = (held >= (QCNT_W + 1)'(QUEUE_DEPTH));
  assign accept = start && !busy;

  ntw_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .time_of_day_sec (in_time_of_day_sec),
    .time_valid      (in_time_valid),
    .cfg             (cfg_r),
    .push            (push),
    .push_item       (push_item),
    .inflight        (inflight)
  );

  ntw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .count     (q_count)
  );

  ntw_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop            (pop),
    .pop_item       (pop_item),
    .cfg            (cfg_r),
    .out_strobe     (out_strobe),
    .out_strength   (out_strength),
    .out_gain_red   (out_gain_red),
    .out_gain_green (out_gain_green),
    .out_gain_blue  (out_gain_blue)
  );

endmodule
